>>> hw/rtl/tlhs_pkg.sv
// shared types and constants of the two-level histogram spread unit
`default_nettype none

package tlhs_pkg;

  // default geometry
  localparam int TOP_BINS_DEF   = 256;
  localparam int CHILD_BINS_DEF = 32;

  // field widths of one item
  localparam int FUNC_W      = 2;
  localparam int TOP_IDX_W   = 8;
  localparam int CHILD_IDX_W = 5;
  localparam int CNT_W       = 32;
  localparam int EXTRA_W     = 8;

  // operation codes carried in tuser
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SINGLE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EVEN   = 2'd2;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // what the back end has to do with one item
  typedef enum logic [1:0] {
    KIND_READ,
    KIND_SINGLE,
    KIND_EVEN,
    KIND_SKIP
  } kind_e;

  typedef struct packed {
    kind_e                  kind;
    logic                   child_ok;
    logic [TOP_IDX_W-1:0]   top_index;
    logic [CHILD_IDX_W-1:0] child_index;
    logic [CNT_W-1:0]       count;
    logic [CNT_W-1:0]       base;
    logic [EXTRA_W-1:0]     extra;
  } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/tlhs_front.sv
// front end: takes items, classifies them and splits the count for an even spread
`default_nettype none

module tlhs_front #(
  parameter int TOP_BINS   = tlhs_pkg::TOP_BINS_DEF,
  parameter int CHILD_BINS = tlhs_pkg::CHILD_BINS_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 en_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [tlhs_pkg::FUNC_W-1:0]          func_i,
  input  wire logic [tlhs_pkg::TOP_IDX_W-1:0]       top_index_i,
  input  wire logic [tlhs_pkg::CHILD_IDX_W-1:0]     child_index_i,
  input  wire logic [tlhs_pkg::CNT_W-1:0]           count_i,
  output logic                                      push_valid_o,
  input  wire logic                                 push_ready_i,
  output tlhs_pkg::cmd_t                            push_data_o
);

  // count / CHILD_BINS as a multiply by a rounded-up reciprocal
  localparam int          Shift  = tlhs_pkg::CNT_W + $clog2(CHILD_BINS);
  localparam logic [64:0] Pow    = 65'd1 << Shift;
  localparam logic [64:0] Mult   = (Pow + 65'(CHILD_BINS) - 65'd1) / 65'(CHILD_BINS);
  localparam logic [32:0] MultLo = Mult[32:0];

  logic                               s1_valid_q, s1_valid_d;
  tlhs_pkg::kind_e                    kind_q, kind_d;
  logic                               child_ok_q, child_ok_d;
  logic [tlhs_pkg::TOP_IDX_W-1:0]     top_q;
  logic [tlhs_pkg::CHILD_IDX_W-1:0]   child_q;
  logic [tlhs_pkg::CNT_W-1:0]         count_q;
  logic [64:0]                        prod_q, prod_d;
  logic                               accept;
  logic                               push;
  logic [tlhs_pkg::CNT_W-1:0]         base;
  logic [tlhs_pkg::CNT_W-1:0]         rem_full;

  assign in_ready_o = en_i && (!s1_valid_q || push_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign push       = s1_valid_q && push_ready_i;

  always_comb begin
    if (32'(top_index_i) >= 32'(TOP_BINS)) begin
      kind_d = tlhs_pkg::KIND_SKIP;
    end else begin
      unique case (func_i)
        tlhs_pkg::FUNC_SINGLE: kind_d = tlhs_pkg::KIND_SINGLE;
        tlhs_pkg::FUNC_EVEN:   kind_d = tlhs_pkg::KIND_EVEN;
        default:               kind_d = tlhs_pkg::KIND_READ;
      endcase
    end
    child_ok_d = 32'(child_index_i) < 32'(CHILD_BINS);
    prod_d     = 65'(count_i) * 65'(MultLo);
    s1_valid_d = accept ? 1'b1 : (push ? 1'b0 : s1_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= kind_d;
      child_ok_q <= child_ok_d;
      top_q      <= top_index_i;
      child_q    <= child_index_i;
      count_q    <= count_i;
      prod_q     <= prod_d;
    end
  end

  // remainder is below CHILD_BINS, so the low bits are exact
  assign base     = 32'(prod_q >> Shift);
  assign rem_full = count_q - base * 32'(CHILD_BINS);

  assign push_valid_o            = s1_valid_q;
  assign push_data_o.kind        = kind_q;
  assign push_data_o.child_ok    = child_ok_q;
  assign push_data_o.top_index   = top_q;
  assign push_data_o.child_index = child_q;
  assign push_data_o.count       = count_q;
  assign push_data_o.base        = base;
  assign push_data_o.extra       = rem_full[tlhs_pkg::EXTRA_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/tlhs_fifo.sv
// short command queue between front end and back end
`default_nettype none

module tlhs_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_valid_i,
  output logic                push_ready_o,
  input  tlhs_pkg::cmd_t      push_data_i,
  output logic                pop_valid_o,
  input  wire logic           pop_ready_i,
  output tlhs_pkg::cmd_t      pop_data_o
);

  tlhs_pkg::cmd_t                 entry_q [tlhs_pkg::Q_DEPTH];
  logic [tlhs_pkg::Q_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [tlhs_pkg::Q_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [tlhs_pkg::Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                           push;
  logic                           pop;

  assign push_ready_o = cnt_q != tlhs_pkg::Q_CNT_W'(tlhs_pkg::Q_DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == tlhs_pkg::Q_PTR_W'(tlhs_pkg::Q_DEPTH - 1)) ? '0
                                                                       : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == tlhs_pkg::Q_PTR_W'(tlhs_pkg::Q_DEPTH - 1)) ? '0
                                                                       : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/tlhs_back.sv
// back end: row memory, read-modify-write of one top bin and its child row, result register
`default_nettype none

module tlhs_back #(
  parameter int TOP_BINS   = tlhs_pkg::TOP_BINS_DEF,
  parameter int CHILD_BINS = tlhs_pkg::CHILD_BINS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  output logic                               clr_done_o,
  input  wire logic                          cmd_valid_i,
  output logic                               cmd_ready_o,
  input  tlhs_pkg::cmd_t                     cmd_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic                               bin_populated_o,
  output logic [tlhs_pkg::CNT_W-1:0]         top_total_o,
  output logic [tlhs_pkg::CNT_W-1:0]         child_total_o
);

  localparam int AW    = $clog2(TOP_BINS);
  localparam int CW    = $clog2(CHILD_BINS);
  localparam int CNTW  = tlhs_pkg::CNT_W;
  localparam int TopLo = CNTW * CHILD_BINS;
  localparam int RowW  = 1 + CNTW + TopLo;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_IDLE   = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  tlhs_pkg::cmd_t         cmd_q;
  logic [RowW-1:0]        mem [TOP_BINS];
  logic [RowW-1:0]        rdata_q;
  logic [RowW-1:0]        new_row;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [RowW-1:0]        mem_wdata;
  logic                   take;
  logic                   fire;
  logic                   upd;
  logic [CW-1:0]          lane;
  logic [CNTW-1:0]        child_sel;
  logic                   out_valid_q, out_valid_d;
  logic                   res_pop;
  logic [CNTW-1:0]        res_top;
  logic [CNTW-1:0]        res_child;

  assign clr_done_o  = state_q != ST_CLEAR;
  assign cmd_ready_o = state_q == ST_IDLE;
  assign take        = cmd_valid_i && cmd_ready_o;
  assign fire        = (state_q == ST_UPDATE) && (!out_valid_q || out_ready_i);
  assign upd         = (cmd_q.kind == tlhs_pkg::KIND_SINGLE) ||
                       (cmd_q.kind == tlhs_pkg::KIND_EVEN);
  assign lane        = CW'(cmd_q.child_index);

  // new row image: populated bit, top counter, then one counter per child
  always_comb begin
    logic [CNTW-1:0] base1;
    logic [CNTW-1:0] addv;
    base1   = cmd_q.base + 32'd1;
    new_row = rdata_q;
    for (int c = 0; c < CHILD_BINS; c++) begin
      addv = '0;
      if (cmd_q.kind == tlhs_pkg::KIND_EVEN) begin
        addv = (c < int'(cmd_q.extra)) ? base1 : cmd_q.base;
      end else if (cmd_q.kind == tlhs_pkg::KIND_SINGLE && cmd_q.child_ok &&
                   lane == CW'(c)) begin
        addv = cmd_q.count;
      end
      new_row[CNTW*c +: CNTW] = rdata_q[CNTW*c +: CNTW] + addv;
    end
    new_row[TopLo +: CNTW] = rdata_q[TopLo +: CNTW] + (upd ? cmd_q.count : '0);
    new_row[RowW-1]        = rdata_q[RowW-1] | upd;
    child_sel              = new_row[CNTW*int'(lane) +: CNTW];
  end

  always_comb begin
    res_pop   = 1'b0;
    res_top   = '0;
    res_child = '0;
    if (cmd_q.kind != tlhs_pkg::KIND_SKIP) begin
      res_pop   = new_row[RowW-1];
      res_top   = new_row[TopLo +: CNTW];
      res_child = cmd_q.child_ok ? child_sel : '0;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(TOP_BINS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (fire) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    mem_we    = (state_q == ST_CLEAR) || (fire && upd);
    mem_waddr = (state_q == ST_CLEAR) ? clr_q : AW'(cmd_q.top_index);
    mem_wdata = (state_q == ST_CLEAR) ? '0 : new_row;
  end

  assign out_valid_d = fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // row memory, read data registered
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (take) begin
      rdata_q <= mem[AW'(cmd_i.top_index)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_i;
    end
    if (fire) begin
      bin_populated_o <= res_pop;
      top_total_o     <= res_top;
      child_total_o   <= res_child;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

>>> hw/rtl/two_level_histogram_spread_unit.sv
// top level of the two-level histogram spread unit
`default_nettype none

// Two-level histogram: TOP_BINS top counters, each with a row of CHILD_BINS child
// counters, all 32 bits and wrapping. An add adds its count to the top bin, marks it
// populated and puts the count either on one child or spread evenly over the row;
// a read only reports. Each input transfer gives exactly one output transfer with
// the populated flag, the top total and the addressed child total. After reset the
// row memory is cleared, all TOP_BINS rows one after another, and s_axis_tready is
// low until that is done. Items pass an input stage and a two-entry queue, then
// the back end handles one item at a time: a registered row read, then update and
// write-back of the whole row, which waits while the output register holds an
// untaken result; it takes no new item before the write-back. Results wait in an
// output register while the front end and queue still take new items.
module two_level_histogram_spread_unit #(
  parameter int TOP_BINS   = tlhs_pkg::TOP_BINS_DEF,
  parameter int CHILD_BINS = tlhs_pkg::CHILD_BINS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // top_index[7:0], child_index[12:8], count[44:13]
  input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata   // bin_populated[0], top_total[32:1], child_total[64:33]
);

  logic                               clr_done;
  logic                               push_valid;
  logic                               push_ready;
  tlhs_pkg::cmd_t                     push_data;
  logic                               pop_valid;
  logic                               pop_ready;
  tlhs_pkg::cmd_t                     pop_data;
  logic                               bin_populated;
  logic [tlhs_pkg::CNT_W-1:0]         top_total;
  logic [tlhs_pkg::CNT_W-1:0]         child_total;

  tlhs_front #(
    .TOP_BINS   (TOP_BINS),
    .CHILD_BINS (CHILD_BINS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (clr_done),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .func_i        (s_axis_tuser),
    .top_index_i   (s_axis_tdata[7:0]),
    .child_index_i (s_axis_tdata[12:8]),
    .count_i       (s_axis_tdata[44:13]),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_data_o   (push_data)
  );

  tlhs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  tlhs_back #(
    .TOP_BINS   (TOP_BINS),
    .CHILD_BINS (CHILD_BINS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .clr_done_o      (clr_done),
    .cmd_valid_i     (pop_valid),
    .cmd_ready_o     (pop_ready),
    .cmd_i           (pop_data),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .bin_populated_o (bin_populated),
    .top_total_o     (top_total),
    .child_total_o   (child_total)
  );

  assign m_axis_tdata = {7'd0, child_total, top_total, bin_populated};

endmodule

`default_nettype wire

>>> sim/two_level_histogram_spread_unit_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the two-level histogram spread unit
module two_level_histogram_spread_unit_tb;

  localparam int NUM_TOP = tlhs_pkg::TOP_BINS_DEF;
  localparam int NUM_CHILD = tlhs_pkg::CHILD_BINS_DEF;
  localparam logic [tlhs_pkg::FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 32;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                       populated;
    logic [tlhs_pkg::CNT_W-1:0] top_total;
    logic [tlhs_pkg::CNT_W-1:0] child_total;
  } bin_report_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;

  // shadow histogram
  logic                       bin_seen [NUM_TOP];
  logic [tlhs_pkg::CNT_W-1:0] bin_sum  [NUM_TOP];
  logic [tlhs_pkg::CNT_W-1:0] leaf_sum [NUM_TOP][NUM_CHILD];
  bin_report_t                pending_reports[$];

  // sender bursts and receiver stalls
  int gap_max = 0;
  int burst_max = 0;
  int burst_left = 0;
  int sink_stall_max = 0;
  int sink_left = 0;

  int idle_cycles = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int func_seen [4] = '{0, 0, 0, 0};
  bin_report_t want_rep;
  bin_report_t got_rep;

  two_level_histogram_spread_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // applies one item to the shadow histogram and returns what the block should report
  function automatic bin_report_t tally_item(input logic [tlhs_pkg::FUNC_W-1:0] func,
                                             input logic [tlhs_pkg::TOP_IDX_W-1:0] top,
                                             input logic [tlhs_pkg::CHILD_IDX_W-1:0] child,
                                             input logic [tlhs_pkg::CNT_W-1:0] cnt);
    bin_report_t rep;
    logic [tlhs_pkg::CNT_W-1:0] share;
    logic [tlhs_pkg::CNT_W-1:0] rem;
    if (func == tlhs_pkg::FUNC_SINGLE || func == tlhs_pkg::FUNC_EVEN) begin
      bin_seen[top] = 1'b1;
      bin_sum[top] = bin_sum[top] + cnt;
      if (func == tlhs_pkg::FUNC_SINGLE) begin
        leaf_sum[top][child] = leaf_sum[top][child] + cnt;
      end else begin
        share = cnt / NUM_CHILD;
        rem = cnt % NUM_CHILD;
        for (int c = 0; c < NUM_CHILD; c++) begin
          leaf_sum[top][c] = leaf_sum[top][c] + share + ((c < rem) ? 1 : 0);
        end
      end
    end
    rep.populated = bin_seen[top];
    rep.top_total = bin_sum[top];
    rep.child_total = leaf_sum[top][child];
    return rep;
  endfunction

  task automatic push_item(input logic [tlhs_pkg::FUNC_W-1:0] func,
                           input logic [tlhs_pkg::TOP_IDX_W-1:0] top,
                           input logic [tlhs_pkg::CHILD_IDX_W-1:0] child,
                           input logic [tlhs_pkg::CNT_W-1:0] cnt);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= {3'b000, cnt, child, top};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_reports.insert(pending_reports.size(), tally_item(func, top, child, cnt));
    func_seen[func]++;
    if (burst_left > 0) begin
      burst_left--;
    end else if (gap_max > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(gap_max, 1)) @(posedge clk_i);
      burst_left = $urandom_range(burst_max, 0);
    end
  endtask

  function automatic logic [tlhs_pkg::CNT_W-1:0] pick_count();
    case ($urandom_range(4, 0))
      0: return $urandom_range(70, 0);
      1: return 32'hFFFF_FFFF - $urandom_range(70, 0);
      2: return $urandom() << 5;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [tlhs_pkg::FUNC_W-1:0] pick_func();
    int r;
    r = $urandom_range(9, 0);
    if (r < 2) return tlhs_pkg::FUNC_READ;
    if (r == 2) return FUNC_SPARE;
    if (r < 6) return tlhs_pkg::FUNC_SINGLE;
    return tlhs_pkg::FUNC_EVEN;
  endfunction

  function automatic void check_field(input string what,
                                      input logic [tlhs_pkg::CNT_W-1:0] want,
                                      input logic [tlhs_pkg::CNT_W-1:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) begin
        $display("%s wrong on result %0d: expected %h, got %h",
                 what, results_checked, want, got);
      end
    end
  endfunction

  // receiver: alternating ready runs and stall runs
  always @(posedge clk_i) begin
    if (sink_stall_max == 0) begin
      m_axis_tready <= 1'b1;
      sink_left <= 0;
    end else if (sink_left == 0) begin
      m_axis_tready <= !m_axis_tready;
      sink_left <= m_axis_tready ? $urandom_range(sink_stall_max, 1) : $urandom_range(20, 1);
    end else begin
      sink_left <= sink_left - 1;
    end
  end

  // result checker and transfer activity
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_rep.populated = m_axis_tdata[0];
      got_rep.top_total = m_axis_tdata[32:1];
      got_rep.child_total = m_axis_tdata[64:33];
      if (pending_reports.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("result with nothing pending: %h", m_axis_tdata);
        end
      end else begin
        want_rep = pending_reports.pop_front();
        check_field("bin_populated", {31'd0, want_rep.populated}, {31'd0, got_rep.populated});
        check_field("top_total", want_rep.top_total, got_rep.top_total);
        check_field("child_total", want_rep.child_total, got_rep.child_total);
      end
      results_checked++;
    end
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("no transfer for %0d cycles, %0d results pending", WATCHDOG_LIMIT,
             pending_reports.size());
    $display("two_level_histogram_spread_unit: mismatch");
    $finish;
  end

  task automatic test_directed_corners();
    gap_max = 0;
    sink_stall_max = 0;
    // untouched bins read back as zero
    push_item(tlhs_pkg::FUNC_READ, 8'd0, 5'd0, 32'd0);
    push_item(tlhs_pkg::FUNC_READ, 8'd255, 5'd31, 32'hFFFF_FFFF);
    // zero count still marks the bin
    push_item(tlhs_pkg::FUNC_SINGLE, 8'd0, 5'd0, 32'd0);
    // wrap of top and child counters
    push_item(tlhs_pkg::FUNC_SINGLE, 8'd255, 5'd31, 32'hFFFF_FFFF);
    push_item(tlhs_pkg::FUNC_SINGLE, 8'd255, 5'd31, 32'hFFFF_FFFF);
    push_item(tlhs_pkg::FUNC_SINGLE, 8'd255, 5'd31, 32'd2);
    // spread with fewer units than children, then with as many and with more
    push_item(tlhs_pkg::FUNC_EVEN, 8'd1, 5'd0, 32'd5);
    push_item(tlhs_pkg::FUNC_READ, 8'd1, 5'd4, 32'd0);
    push_item(tlhs_pkg::FUNC_READ, 8'd1, 5'd5, 32'd0);
    push_item(tlhs_pkg::FUNC_EVEN, 8'd2, 5'd31, 32'd31);
    push_item(tlhs_pkg::FUNC_READ, 8'd2, 5'd30, 32'd0);
    push_item(tlhs_pkg::FUNC_EVEN, 8'd3, 5'd17, 32'd32);
    sink_stall_max = 4;
    push_item(tlhs_pkg::FUNC_EVEN, 8'd4, 5'd0, 32'hFFFF_FFFF);
    push_item(tlhs_pkg::FUNC_READ, 8'd4, 5'd31, 32'd0);
    push_item(tlhs_pkg::FUNC_EVEN, 8'd4, 5'd31, 32'hFFFF_FFFF);
    // unused code acts as a read; then a zero-count spread and two single adds
    push_item(FUNC_SPARE, 8'd4, 5'd0, 32'h1234_5678);
    push_item(FUNC_SPARE, 8'd200, 5'd9, 32'hFFFF_FFFF);
    push_item(tlhs_pkg::FUNC_EVEN, 8'd5, 5'd0, 32'd0);
    push_item(tlhs_pkg::FUNC_SINGLE, 8'd170, 5'd21, 32'hAAAA_AAAA);
    push_item(tlhs_pkg::FUNC_SINGLE, 8'd85, 5'd10, 32'h5555_5555);
    // back-to-back updates of one bin
    sink_stall_max = 0;
    push_item(tlhs_pkg::FUNC_SINGLE, 8'd6, 5'd3, 32'd1);
    push_item(tlhs_pkg::FUNC_EVEN, 8'd6, 5'd3, 32'd100);
    push_item(tlhs_pkg::FUNC_SINGLE, 8'd6, 5'd3, 32'd7);
    push_item(tlhs_pkg::FUNC_READ, 8'd6, 5'd3, 32'd0);
  endtask

  task automatic test_random_mix();
    logic [tlhs_pkg::TOP_IDX_W-1:0] top;
    for (int n = 0; n < 450; n++) begin
      if (n % 90 == 0) begin
        gap_max = $urandom_range(8, 0);
        burst_max = $urandom_range(12, 0);
        case ($urandom_range(3, 0))
          0: sink_stall_max = 0;
          1: sink_stall_max = 2;
          2: sink_stall_max = 10;
          default: sink_stall_max = 24;
        endcase
      end
      top = 8'($urandom_range(1, 0) ? $urandom_range(7, 0) : $urandom_range(255, 0));
      push_item(pick_func(), top, 5'($urandom_range(31, 0)), pick_count());
    end
  endtask

  task automatic test_hot_bin_wrap();
    gap_max = 3;
    burst_max = 6;
    sink_stall_max = 6;
    for (int n = 0; n < 150; n++) begin
      push_item(pick_func(), $urandom_range(1, 0) ? 8'd254 : 8'd9,
                5'($urandom_range(31, 0)), 32'hF000_0000 | $urandom());
    end
  endtask

  task automatic test_back_to_back();
    gap_max = 0;
    for (int n = 0; n < 230; n++) begin
      sink_stall_max = (n < 115) ? 0 : 3;
      push_item(pick_func(), 8'($urandom_range(3, 0)), 5'($urandom_range(31, 0)),
                pick_count());
    end
  endtask

  initial begin
    for (int t = 0; t < NUM_TOP; t++) begin
      bin_seen[t] = 1'b0;
      bin_sum[t] = '0;
      for (int c = 0; c < NUM_CHILD; c++) begin
        leaf_sum[t][c] = '0;
      end
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_corners();
    test_random_mix();
    test_hot_bin_wrap();
    test_back_to_back();
    s_axis_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d reads, %0d single adds, %0d even spreads, %0d unused-code items",
             func_seen[tlhs_pkg::FUNC_READ], func_seen[tlhs_pkg::FUNC_SINGLE],
             func_seen[tlhs_pkg::FUNC_EVEN], func_seen[FUNC_SPARE]);
    $display("checked %0d results, %0d field errors", results_checked, mismatch_count);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("two_level_histogram_spread_unit: match");
    end else begin
      $display("two_level_histogram_spread_unit: mismatch");
    end
    $finish;
  end

endmodule

>>> two_level_histogram_spread_unit.f
hw/rtl/tlhs_pkg.sv
hw/rtl/tlhs_front.sv
hw/rtl/tlhs_fifo.sv
hw/rtl/tlhs_back.sv
hw/rtl/two_level_histogram_spread_unit.sv
sim/two_level_histogram_spread_unit_tb.sv
